/* rtl/core/tiny_mlp_online_trainer_defines.svh */
// assertion macros for the trainer core
`ifndef TINY_MLP_ONLINE_TRAINER_DEFINES_SVH
`define TINY_MLP_ONLINE_TRAINER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TMLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tmlp assertion failed");
`define TMLP_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("tmlp forbidden condition");
`else
`define TMLP_ASSERT(lbl, prop)
`define TMLP_ASSERT_NEVER(lbl, prop)
`endif

`endif

/* rtl/core/tmlp_pkg.sv */
`default_nettype none

package tmlp_pkg;

  localparam int unsigned VAL_BITS  = 17;
  localparam int unsigned WORD_BITS = 24;
  localparam int unsigned RATE_BITS = 16;
  localparam int unsigned WIDX_BITS = 4;
  localparam int unsigned CFG_BITS  = 2;
  localparam int unsigned NUM_W     = 9;

  localparam logic [WIDX_BITS-1:0] LAST_SLOT = 4'd8;

  localparam logic [1:0] FUNC_INFER = 2'd0;
  localparam logic [1:0] FUNC_TRAIN = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] PULL_NONE = 2'd0;
  localparam logic [1:0] PULL_UP   = 2'd1;
  localparam logic [1:0] PULL_DOWN = 2'd2;

  localparam logic [CFG_BITS-1:0] CFG_RATE = 2'd0;
  localparam logic [CFG_BITS-1:0] CFG_UP   = 2'd1;
  localparam logic [CFG_BITS-1:0] CFG_DOWN = 2'd2;
  localparam logic [CFG_BITS-1:0] CFG_DEC  = 2'd3;

  localparam logic [RATE_BITS-1:0] RATE_RST = 16'd655;
  localparam logic [VAL_BITS-1:0]  UP_RST   = 17'd45875;
  localparam logic [VAL_BITS-1:0]  DOWN_RST = 17'd19661;
  localparam logic [VAL_BITS-1:0]  DEC_RST  = 17'd52429;

  typedef struct packed {
    logic [1:0]                  func;
    logic [VAL_BITS-1:0]         x_in;
    logic [VAL_BITS-1:0]         y_in;
    logic                        target_label;
    logic [WIDX_BITS-1:0]        weight_index;
    logic signed [WORD_BITS-1:0] weight_value;
  } tmlp_in_t;

  typedef struct packed {
    logic [VAL_BITS-1:0]         score;
    logic                        predicted;
    logic [1:0]                  pull_dir;
    logic signed [WORD_BITS-1:0] weight_read;
  } tmlp_out_t;

  typedef enum logic [2:0] {
    OPB_X,
    OPB_Y,
    OPB_ONE,
    OPB_H0,
    OPB_H1
  } opb_sel_e;

  typedef struct packed {
    logic [WIDX_BITS-1:0] waddr;
    logic                 opa_rate;
    opb_sel_e             opb;
    logic                 acc_first;
    logic                 acc_add;
    logic                 cap_h0;
    logic                 cap_h1;
    logic                 cap_out;
    logic                 upd_we;
    logic                 pull_neg;
    logic                 ext_we;
  } tmlp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/tiny_mlp_online_trainer.sv */
// from accepted word to result valid: infer and train run the forward pass, and a train
// word that pulls then runs the update pass; a write or read of a weight runs the access step
// one word at a time: the next word can be taken in the cycle after the result is loaded,
// with the work per word set by the single shared multiplier (9 forward, 9 update)
// async active-low reset clears all weights to zero and loads the threshold defaults
`default_nettype none
`include "tiny_mlp_online_trainer_defines.svh"

module tiny_mlp_online_trainer import tmlp_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tmlp_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tmlp_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_BITS-1:0] cfg_index_i,
  input  logic [VAL_BITS-1:0] cfg_data_i
);

  logic [RATE_BITS-1:0] rate_q;
  logic [VAL_BITS-1:0]  up_q;
  logic [VAL_BITS-1:0]  down_q;
  logic [VAL_BITS-1:0]  dec_q;

  tmlp_ctrl_t                    ctrl;
  logic [FRAC_BITS:0]            act;
  logic [2:0]                    pos;
  logic signed [WORD_BITS-1:0]   rd_word;
  logic [FRAC_BITS:0]            x_val;
  logic [FRAC_BITS:0]            y_val;
  logic signed [WORD_BITS-1:0]   wr_value;
  logic                          wr_en;
  logic signed [WEIGHT_BITS-1:0] wr_data;
  logic signed [WEIGHT_BITS-1:0] rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      up_q   <= UP_RST;
      down_q <= DOWN_RST;
      dec_q  <= DEC_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RATE: rate_q <= cfg_data_i[RATE_BITS-1:0];
        CFG_UP:   up_q   <= cfg_data_i;
        CFG_DOWN: down_q <= cfg_data_i;
        CFG_DEC:  dec_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  tmlp_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_o       (out_data_o),
    .pull_up_below_i  (up_q),
    .pull_down_above_i(down_q),
    .decide_above_i   (dec_q),
    .act_i            (act),
    .pos_i            (pos),
    .rd_word_i        (rd_word),
    .x_o              (x_val),
    .y_o              (y_val),
    .value_o          (wr_value),
    .ctrl_o           (ctrl)
  );

  tmlp_alu #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_alu (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .rate_i   (rate_q),
    .x_i      (x_val),
    .y_i      (y_val),
    .value_i  (wr_value),
    .rd_i     (rd_data),
    .act_o    (act),
    .pos_o    (pos),
    .we_o     (wr_en),
    .wdata_o  (wr_data),
    .rd_word_o(rd_word)
  );

  tmlp_wregs #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_wregs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (ctrl.waddr),
    .we_i   (wr_en),
    .wdata_i(wr_data),
    .rdata_o(rd_data)
  );

  `TMLP_ASSERT(a_accept_then_busy, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `TMLP_ASSERT(a_write_only_busy, wr_en |-> in_stall_o)
  `TMLP_ASSERT_NEVER(a_upd_ext_clash, ctrl.upd_we && ctrl.ext_we)

endmodule

`default_nettype wire

/* rtl/core/tmlp_wregs.sv */
`default_nettype none

module tmlp_wregs import tmlp_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [WIDX_BITS-1:0]          addr_i,
  input  logic                          we_i,
  input  logic signed [WEIGHT_BITS-1:0] wdata_i,
  output logic signed [WEIGHT_BITS-1:0] rdata_o
);

  logic signed [WEIGHT_BITS-1:0] w_q [NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_W; i++) begin
        w_q[i] <= '0;
      end
    end else if (we_i && (addr_i <= LAST_SLOT)) begin
      w_q[addr_i] <= wdata_i;
    end
  end

  // slots past the last weight read as zero
  assign rdata_o = (addr_i <= LAST_SLOT) ? w_q[addr_i] : '0;

endmodule

`default_nettype wire

/* rtl/core/tmlp_alu.sv */
`default_nettype none

module tmlp_alu import tmlp_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  tmlp_ctrl_t                    ctrl_i,
  input  logic [RATE_BITS-1:0]          rate_i,
  input  logic [FRAC_BITS:0]            x_i,
  input  logic [FRAC_BITS:0]            y_i,
  input  logic signed [WORD_BITS-1:0]   value_i,
  input  logic signed [WEIGHT_BITS-1:0] rd_i,
  output logic [FRAC_BITS:0]            act_o,
  output logic [2:0]                    pos_o,
  output logic                          we_o,
  output logic signed [WEIGHT_BITS-1:0] wdata_o,
  output logic signed [WORD_BITS-1:0]   rd_word_o
);

  localparam int unsigned W  = WEIGHT_BITS;
  localparam int unsigned VB = FRAC_BITS + 1;
  localparam int unsigned PW = W + VB + 1;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned AW = ((W > VB) ? W : VB) + 3;
  localparam int unsigned EW = ((W > WORD_BITS) ? W : WORD_BITS) + 1;

  localparam logic [VB-1:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] ONE_A = AW'(ONE_V);
  localparam logic signed [SW-1:0] S_WMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] S_WMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [EW-1:0] E_WMAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] E_WMIN = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [EW-1:0] E_PMAX = {{(EW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [EW-1:0] E_PMIN = {{(EW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  logic signed [W-1:0]  opa;
  logic [VB-1:0]        opb_v;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p_q;
  logic signed [PW-1:0] fs;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] acc_d;
  logic                 acc_pos;
  logic [VB-1:0]        act;
  logic [VB-1:0]        h0_q;
  logic [VB-1:0]        h1_q;
  logic [2:0]           pos_q;
  logic signed [PW-1:0] step;
  logic signed [SW-1:0] upd_sum;
  logic signed [W-1:0]  upd_w;
  logic signed [EW-1:0] val_e;
  logic signed [W-1:0]  ext_w;
  logic signed [EW-1:0] rd_e;

  assign opa = ctrl_i.opa_rate ? signed'({{(W-RATE_BITS){1'b0}}, rate_i}) : rd_i;

  always_comb begin
    unique case (ctrl_i.opb)
      OPB_X:   opb_v = x_i;
      OPB_Y:   opb_v = y_i;
      OPB_ONE: opb_v = ONE_V;
      OPB_H0:  opb_v = h0_q;
      OPB_H1:  opb_v = h1_q;
      default: opb_v = ONE_V;
    endcase
  end

  // the one shared multiplier
  assign prod = PW'(opa) * PW'(signed'({1'b0, opb_v}));

  // floor of product over one, summed into the pre-activation
  assign fs    = p_q >>> FRAC_BITS;
  assign acc_d = (ctrl_i.acc_first ? '0 : acc_q) + AW'(fs);

  assign acc_pos = !acc_q[AW-1] && (acc_q != '0);

  always_comb begin
    if (!acc_pos) begin
      act = '0;
    end else if (acc_q > ONE_A) begin
      act = ONE_V;
    end else begin
      act = acc_q[VB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (ctrl_i.acc_first || ctrl_i.acc_add) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.cap_h0) begin
      h0_q     <= act;
      pos_q[0] <= acc_pos;
    end
    if (ctrl_i.cap_h1) begin
      h1_q     <= act;
      pos_q[1] <= acc_pos;
    end
    if (ctrl_i.cap_out) begin
      pos_q[2] <= acc_pos;
    end
  end

  // weight step: rate times operand, truncated, then signed by the pull
  assign step    = p_q >>> RATE_BITS;
  assign upd_sum = SW'(rd_i) + (ctrl_i.pull_neg ? -SW'(step) : SW'(step));

  always_comb begin
    if (upd_sum > S_WMAX) begin
      upd_w = S_WMAX[W-1:0];
    end else if (upd_sum < S_WMIN) begin
      upd_w = S_WMIN[W-1:0];
    end else begin
      upd_w = upd_sum[W-1:0];
    end
  end

  assign val_e = EW'(value_i);

  always_comb begin
    if (val_e > E_WMAX) begin
      ext_w = E_WMAX[W-1:0];
    end else if (val_e < E_WMIN) begin
      ext_w = E_WMIN[W-1:0];
    end else begin
      ext_w = val_e[W-1:0];
    end
  end

  assign rd_e = EW'(rd_i);

  always_comb begin
    if (rd_e > E_PMAX) begin
      rd_word_o = E_PMAX[WORD_BITS-1:0];
    end else if (rd_e < E_PMIN) begin
      rd_word_o = E_PMIN[WORD_BITS-1:0];
    end else begin
      rd_word_o = rd_e[WORD_BITS-1:0];
    end
  end

  assign act_o   = act;
  assign pos_o   = pos_q;
  assign we_o    = ctrl_i.upd_we || ctrl_i.ext_we;
  assign wdata_o = ctrl_i.ext_we ? ext_w : upd_w;

endmodule

`default_nettype wire

/* rtl/core/tmlp_seq.sv */
`default_nettype none

module tmlp_seq import tmlp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tmlp_in_t                    in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tmlp_out_t                   out_data_o,
  input  logic [VAL_BITS-1:0]         pull_up_below_i,
  input  logic [VAL_BITS-1:0]         pull_down_above_i,
  input  logic [VAL_BITS-1:0]         decide_above_i,
  input  logic [FRAC_BITS:0]          act_i,
  input  logic [2:0]                  pos_i,
  input  logic signed [WORD_BITS-1:0] rd_word_i,
  output logic [FRAC_BITS:0]          x_o,
  output logic [FRAC_BITS:0]          y_o,
  output logic signed [WORD_BITS-1:0] value_o,
  output tmlp_ctrl_t                  ctrl_o
);

  localparam int unsigned VB = FRAC_BITS + 1;
  localparam int unsigned CW = (VB > VAL_BITS) ? VB : VAL_BITS;

  localparam logic [VB-1:0] ONE_V    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [3:0]    FWD_LAST = 4'd10;
  localparam logic [3:0]    UPD_LAST = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_UPD,
    ST_ACC,
    ST_FIN
  } state_e;

  state_e      state_q;
  logic [3:0]  cnt_q;
  tmlp_in_t    in_q;
  logic [VB-1:0] x_q;
  logic [VB-1:0] y_q;
  logic        pull_neg_q;
  tmlp_out_t   res_q;
  tmlp_out_t   out_q;
  logic        out_valid_q;

  logic          accept;
  logic [CW-1:0] x_w;
  logic [CW-1:0] y_w;
  logic [VB-1:0] x_sat;
  logic [VB-1:0] y_sat;
  logic [CW-1:0] score_w;
  logic          is_train;
  logic          pull_up;
  logic          pull_dn;
  logic          pred;
  logic [1:0]    dir;
  logic [3:0]    slot;

  function automatic opb_sel_e slot_opb(input logic [3:0] s);
    opb_sel_e r;
    unique case (s)
      4'd0, 4'd3: r = OPB_X;
      4'd1, 4'd4: r = OPB_Y;
      4'd6:       r = OPB_H0;
      4'd7:       r = OPB_H1;
      default:    r = OPB_ONE;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] slot_neuron(input logic [3:0] s);
    logic [1:0] r;
    if (s < 4'd3) begin
      r = 2'd0;
    end else if (s < 4'd6) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // inputs above one saturate
  assign x_w   = CW'(in_data_i.x_in);
  assign y_w   = CW'(in_data_i.y_in);
  assign x_sat = (x_w > CW'(ONE_V)) ? ONE_V : x_w[VB-1:0];
  assign y_sat = (y_w > CW'(ONE_V)) ? ONE_V : y_w[VB-1:0];

  assign score_w  = CW'(act_i);
  assign is_train = (in_q.func == FUNC_TRAIN);
  assign pull_up  = in_q.target_label && (score_w < CW'(pull_up_below_i));
  assign pull_dn  = !in_q.target_label && (score_w > CW'(pull_down_above_i));
  assign pred     = (score_w > CW'(decide_above_i));
  assign slot     = cnt_q - 4'd1;

  always_comb begin
    if (!is_train) begin
      dir = PULL_NONE;
    end else if (pull_up) begin
      dir = PULL_UP;
    end else if (pull_dn) begin
      dir = PULL_DOWN;
    end else begin
      dir = PULL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      in_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      pull_neg_q  <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            in_q  <= in_data_i;
            x_q   <= x_sat;
            y_q   <= y_sat;
            cnt_q <= '0;
            if (in_data_i.func == FUNC_INFER || in_data_i.func == FUNC_TRAIN) begin
              state_q <= ST_FWD;
            end else begin
              state_q <= ST_ACC;
            end
          end
        end
        ST_FWD: begin
          if (cnt_q == FWD_LAST) begin
            cnt_q <= '0;
            res_q <= '{score: score_w[VAL_BITS-1:0], predicted: pred,
                       pull_dir: dir, weight_read: '0};
            if (is_train && (pull_up || pull_dn)) begin
              state_q    <= ST_UPD;
              pull_neg_q <= pull_dn;
            end else begin
              state_q <= ST_FIN;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_UPD: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == UPD_LAST) begin
            state_q <= ST_FIN;
          end
        end
        ST_ACC: begin
          res_q <= '{score: '0, predicted: 1'b0, pull_dir: PULL_NONE,
                     weight_read: (in_q.func == FUNC_READ) ? rd_word_i : '0};
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // microcode: forward pass issues one product a cycle, each summed from the registered product
  always_comb begin
    ctrl_o     = '0;
    ctrl_o.opb = OPB_X;
    unique case (state_q)
      ST_FWD: begin
        unique case (cnt_q)
          4'd0: begin
            ctrl_o.waddr = 4'd0;
            ctrl_o.opb   = OPB_X;
          end
          4'd1: begin
            ctrl_o.waddr     = 4'd1;
            ctrl_o.opb       = OPB_Y;
            ctrl_o.acc_first = 1'b1;
          end
          4'd2: begin
            ctrl_o.waddr   = 4'd2;
            ctrl_o.opb     = OPB_ONE;
            ctrl_o.acc_add = 1'b1;
          end
          4'd3: begin
            ctrl_o.waddr   = 4'd3;
            ctrl_o.opb     = OPB_X;
            ctrl_o.acc_add = 1'b1;
          end
          4'd4: begin
            ctrl_o.waddr     = 4'd4;
            ctrl_o.opb       = OPB_Y;
            ctrl_o.acc_first = 1'b1;
            ctrl_o.cap_h0    = 1'b1;
          end
          4'd5: begin
            ctrl_o.waddr   = 4'd5;
            ctrl_o.opb     = OPB_ONE;
            ctrl_o.acc_add = 1'b1;
          end
          4'd6: begin
            ctrl_o.waddr   = 4'd6;
            ctrl_o.opb     = OPB_H0;
            ctrl_o.acc_add = 1'b1;
          end
          4'd7: begin
            ctrl_o.waddr     = 4'd8;
            ctrl_o.opb       = OPB_ONE;
            ctrl_o.acc_first = 1'b1;
            ctrl_o.cap_h1    = 1'b1;
          end
          4'd8: begin
            ctrl_o.waddr   = 4'd7;
            ctrl_o.opb     = OPB_H1;
            ctrl_o.acc_add = 1'b1;
          end
          4'd9: begin
            ctrl_o.acc_add = 1'b1;
          end
          4'd10: begin
            ctrl_o.cap_out = 1'b1;
          end
          default: ;
        endcase
      end
      ST_UPD: begin
        if (cnt_q < UPD_LAST) begin
          ctrl_o.opa_rate = 1'b1;
          ctrl_o.opb      = slot_opb(cnt_q);
        end
        if (cnt_q != 4'd0) begin
          ctrl_o.waddr    = slot;
          ctrl_o.upd_we   = pos_i[slot_neuron(slot)];
          ctrl_o.pull_neg = pull_neg_q;
        end
      end
      ST_ACC: begin
        ctrl_o.waddr  = in_q.weight_index;
        ctrl_o.ext_we = (in_q.func == FUNC_WRITE);
      end
      default: ;
    endcase
  end

  assign x_o         = x_q;
  assign y_o         = y_q;
  assign value_o     = in_q.weight_value;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* tb/tiny_mlp_online_trainer_tb.sv */
`default_nettype none

module tiny_mlp_online_trainer_tb import tmlp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC_BITS   = 16;
  localparam longint ONE         = 1 << FRAC_BITS;
  localparam longint W_MAX       = (longint'(1) << 23) - 1;
  localparam longint W_MIN       = -(longint'(1) << 23);
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     PHASE_WORDS = 225;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tmlp_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tmlp_out_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_BITS-1:0] cfg_index_i = CFG_RATE;
  logic [VAL_BITS-1:0] cfg_data_i  = '0;

  tiny_mlp_online_trainer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // mirror of the network: weights, thresholds and the results still owed
  class mlp_mirror;
    longint      weights[NUM_W];
    longint      learn_rate, up_below, down_above, decide_above;
    tmlp_out_t   expected_results[$];
    int unsigned errors, n_checked, n_up, n_down, n_clip, n_over_one;
    int unsigned n_func[4];

    function new();
      foreach (weights[i]) weights[i] = 0;
      learn_rate   = RATE_RST;
      up_below     = UP_RST;
      down_above   = DOWN_RST;
      decide_above = DEC_RST;
      errors       = 0;
      n_checked    = 0;
      n_up         = 0;
      n_down       = 0;
      n_clip       = 0;
      n_over_one   = 0;
      foreach (n_func[i]) n_func[i] = 0;
    endfunction

    function void set_reg(logic [CFG_BITS-1:0] idx, logic [VAL_BITS-1:0] val);
      case (idx)
        CFG_RATE: learn_rate   = val[RATE_BITS-1:0];
        CFG_UP:   up_below     = val;
        CFG_DOWN: down_above   = val;
        CFG_DEC:  decide_above = val;
        default: ;
      endcase
    endfunction

    function longint neuron_pre(int n, longint u, longint v);
      return ((weights[3*n] * u) >>> FRAC_BITS) + ((weights[3*n+1] * v) >>> FRAC_BITS)
             + weights[3*n+2];
    endfunction

    function longint relu_clip(longint p);
      return (p < 0) ? 0 : ((p > ONE) ? ONE : p);
    endfunction

    function void nudge(int slot, bit down, longint operand);
      longint d, w;
      d = (learn_rate * operand) >> RATE_BITS;
      w = down ? weights[slot] - d : weights[slot] + d;
      if (w > W_MAX) begin
        w = W_MAX;
        n_clip++;
      end else if (w < W_MIN) begin
        w = W_MIN;
        n_clip++;
      end
      weights[slot] = w;
    endfunction

    function void note_word(tmlp_in_t w);
      tmlp_out_t want;
      longint    x, y, p0, p1, p2, h0, h1, score;
      bit        pulls, down;
      want = '0;
      n_func[w.func]++;
      case (w.func)
        FUNC_INFER, FUNC_TRAIN: begin
          if (w.x_in > ONE || w.y_in > ONE) n_over_one++;
          x     = (w.x_in > ONE) ? ONE : longint'(w.x_in);
          y     = (w.y_in > ONE) ? ONE : longint'(w.y_in);
          p0    = neuron_pre(0, x, y);
          p1    = neuron_pre(1, x, y);
          h0    = relu_clip(p0);
          h1    = relu_clip(p1);
          p2    = neuron_pre(2, h0, h1);
          score = relu_clip(p2);
          want.score     = score[VAL_BITS-1:0];
          want.predicted = (score > decide_above);
          if (w.func == FUNC_TRAIN) begin
            pulls = 1'b0;
            down  = 1'b0;
            if (w.target_label && score < up_below) begin
              pulls         = 1'b1;
              want.pull_dir = PULL_UP;
              n_up++;
            end else if (!w.target_label && score > down_above) begin
              pulls         = 1'b1;
              down          = 1'b1;
              want.pull_dir = PULL_DOWN;
              n_down++;
            end
            if (pulls) begin
              if (p2 > 0) begin
                nudge(6, down, h0);
                nudge(7, down, h1);
                nudge(8, down, ONE);
              end
              if (p1 > 0) begin
                nudge(3, down, x);
                nudge(4, down, y);
                nudge(5, down, ONE);
              end
              if (p0 > 0) begin
                nudge(0, down, x);
                nudge(1, down, y);
                nudge(2, down, ONE);
              end
            end
          end
        end
        FUNC_WRITE: begin
          if (w.weight_index <= LAST_SLOT)
            weights[w.weight_index] = longint'($signed(w.weight_value));
        end
        default: begin
          if (w.weight_index <= LAST_SLOT)
            want.weight_read = weights[w.weight_index][WORD_BITS-1:0];
        end
      endcase
      expected_results.push_back(want);
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      if (errors < 40)
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_word(input tmlp_out_t got);
      tmlp_out_t want;
      if (expected_results.size() == 0) begin
        report("word with nothing pending", got.score, '0);
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      if (got.score !== want.score) report("score", got.score, want.score);
      if (got.predicted !== want.predicted)
        report("predicted", got.predicted, want.predicted);
      if (got.pull_dir !== want.pull_dir) report("pull_dir", got.pull_dir, want.pull_dir);
      if (got.weight_read !== want.weight_read)
        report("weight_read", got.weight_read, want.weight_read);
    endtask
  endclass

  mlp_mirror   mirror = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.check_word(out_data_o);
  end

  function automatic tmlp_in_t word_of(logic [1:0] f, logic [VAL_BITS-1:0] x,
                                       logic [VAL_BITS-1:0] y, logic lbl,
                                       logic [WIDX_BITS-1:0] idx,
                                       logic [WORD_BITS-1:0] val);
    tmlp_in_t w;
    w.func         = f;
    w.x_in         = x;
    w.y_in         = y;
    w.target_label = lbl;
    w.weight_index = idx;
    w.weight_value = val;
    return w;
  endfunction

  function automatic logic [VAL_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VAL_BITS'(ONE);
      2:       return VAL_BITS'($urandom_range(ONE + 1, 131071));
      default: return VAL_BITS'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic tmlp_in_t random_word();
    tmlp_in_t    w;
    int unsigned pick;
    w.x_in         = pick_value();
    w.y_in         = pick_value();
    w.target_label = 1'($urandom_range(0, 1));
    w.weight_index = ($urandom_range(0, 9) == 0) ? WIDX_BITS'($urandom_range(9, 15))
                                                 : WIDX_BITS'($urandom_range(0, 8));
    w.weight_value = ($urandom_range(0, 3) == 0) ? WORD_BITS'($urandom)
                                                 : WORD_BITS'($urandom_range(0, 4 * ONE) - 2 * ONE);
    pick = $urandom_range(0, 99);
    if (pick < 10)      w.func = FUNC_WRITE;
    else if (pick < 25) w.func = FUNC_READ;
    else if (pick < 45) w.func = FUNC_INFER;
    else                w.func = FUNC_TRAIN;
    return w;
  endfunction

  task automatic send_word(input tmlp_in_t w);
    int unsigned gap;
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.note_word(w);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mirror.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [VAL_BITS-1:0] rate, input logic [VAL_BITS-1:0] up_lim,
                            input logic [VAL_BITS-1:0] down_lim,
                            input logic [VAL_BITS-1:0] dec_lim);
    logic [CFG_BITS-1:0] regs[4];
    logic [VAL_BITS-1:0] vals[4];
    int                  i;
    regs = '{CFG_RATE, CFG_UP, CFG_DOWN, CFG_DEC};
    vals = '{rate, up_lim, down_lim, dec_lim};
    for (i = 0; i < 4; i++) begin
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      mirror.set_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int ph, k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero weights, out of range slots, weight extremes, inputs above one
    send_word(word_of(FUNC_INFER, 0, 0, 1'b0, 0, 0));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 15, 0));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 9, 12345));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 9, 0));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 0, 8388607));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 1, -8388608));
    send_word(word_of(FUNC_INFER, 131071, 131071, 1'b1, 0, 0));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 0, 0));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 1, 0));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 2, 65536));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 3, 32768));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 5, 16384));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 6, 65536));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 7, 32768));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 8, 8192));
    // no pull either way, then a pull down and a pull up
    send_word(word_of(FUNC_TRAIN, 65536, 0, 1'b1, 0, 0));
    send_word(word_of(FUNC_TRAIN, 0, 65536, 1'b0, 0, 0));
    send_word(word_of(FUNC_TRAIN, 65536, 0, 1'b0, 0, 0));
    send_word(word_of(FUNC_TRAIN, 0, 65536, 1'b1, 0, 0));
    send_word(word_of(FUNC_INFER, 65536, 65536, 1'b0, 0, 0));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 6, 0));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 3, 0));
    send_word(word_of(FUNC_READ, 0, 0, 1'b0, 2, 0));
    send_word(word_of(FUNC_WRITE, 0, 0, 1'b0, 4, 24'hFFFFFF));
    send_word(word_of(FUNC_TRAIN, 1, 131071, 1'b0, 0, 0));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_regs(17'd65535, 17'd65536, 17'd0, 17'd0);
        1:       write_regs(17'd0, 17'd0, 17'd65536, 17'd65536);
        2:       write_regs(17'h12345, 17'd30000, 17'd30000, 17'd30000);
        3:       write_regs(VAL_BITS'(RATE_RST), UP_RST, DOWN_RST, DEC_RST);
        4:       write_regs(VAL_BITS'($urandom_range(1, 65535)),
                            VAL_BITS'($urandom_range(0, 65536)),
                            VAL_BITS'($urandom_range(0, 65536)),
                            VAL_BITS'($urandom_range(0, 65536)));
        default: write_regs(VAL_BITS'($urandom_range(4096, 65535)),
                            VAL_BITS'($urandom_range(0, 65536)),
                            VAL_BITS'($urandom_range(0, 65536)),
                            VAL_BITS'($urandom_range(0, 65536)));
      endcase
      // mostly live neurons so that training moves weights
      for (k = 0; k <= LAST_SLOT; k++)
        send_word(word_of(FUNC_WRITE, pick_value(), pick_value(), 1'($urandom_range(0, 1)),
                          WIDX_BITS'(k),
                          WORD_BITS'($urandom_range(0, 3 * ONE / 2) - ONE / 4)));
      repeat (PHASE_WORDS) send_word(random_word());
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("run covered %0d words (%0d infer, %0d train, %0d write, %0d read), %0d checked",
             mirror.n_func[FUNC_INFER] + mirror.n_func[FUNC_TRAIN] + mirror.n_func[FUNC_WRITE]
             + mirror.n_func[FUNC_READ], mirror.n_func[FUNC_INFER], mirror.n_func[FUNC_TRAIN],
             mirror.n_func[FUNC_WRITE], mirror.n_func[FUNC_READ], mirror.n_checked);
    $display("seven threshold settings: %0d pulls up, %0d down, %0d clipped updates, %0d over one",
             mirror.n_up, mirror.n_down, mirror.n_clip, mirror.n_over_one);
    if (mirror.errors == 0 && mirror.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/tmlp_pkg.sv
rtl/core/tmlp_wregs.sv
rtl/core/tmlp_alu.sv
rtl/core/tmlp_seq.sv
rtl/core/tiny_mlp_online_trainer.sv
tb/tiny_mlp_online_trainer_tb.sv
